@@ sv/bdsmp_pkg.sv @@
// package for the 2x2 box downsampler
// shared constants and types; no dependencies

package bdsmp_pkg;

	localparam int CFG_W   = 12;
	localparam int IDX_W   = 2;
	localparam int PIX_W   = 8;
	localparam int NUM_CH  = 4;
	localparam int PAIR_W  = PIX_W + 1;
	localparam int QUAD_W  = PIX_W + 2;
	localparam int MIN_DIM = 2;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

	// per-pixel actions decided from the raster position
	typedef struct packed {
		logic hold;
		logic store;
		logic emit;
		logic last;
	} pos_info_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
		logic             last;
	} result_t;

endpackage

@@ sv/bdsmp_ram.sv @@
// generic single-clock ram, one write and one read port, registered read
// no dependencies

module bdsmp_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bdsmp_pos.sv @@
// configuration registers and raster position counters
// depends on bdsmp_pkg

module bdsmp_pos #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int SLOT_W     = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [bdsmp_pkg::IDX_W-1:0] cfg_index,
	input  logic [bdsmp_pkg::CFG_W-1:0] cfg_data,
	input  logic                        fire,
	output bdsmp_pkg::pos_info_t        info,
	output logic [SLOT_W-1:0]           slot,
	output logic                        has_alpha
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int M1 = (WW > HW) ? WW : HW;
	localparam int M2 = (M1 > bdsmp_pkg::CFG_W) ? M1 : bdsmp_pkg::CFG_W;
	localparam int CMP_W = M2 + 1;
	localparam int W_RST = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
	localparam int H_RST = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

	logic [WW-1:0]    width_q;
	logic [HW-1:0]    height_q;
	logic             has_alpha_q;
	logic [WW-1:0]    col_q;
	logic [HW-1:0]    row_q;
	logic [CMP_W-1:0] cfg_x;
	logic [WW-1:0]    width_new;
	logic [HW-1:0]    height_new;
	logic [CMP_W-1:0] col_x;
	logic [CMP_W-1:0] row_x;
	logic [CMP_W-1:0] w_x;
	logic [CMP_W-1:0] h_x;
	logic [CMP_W-1:0] w_used;
	logic [CMP_W-1:0] h_used;
	logic             in_img;
	logic             row_end;
	logic             img_end;

	// sizes are clamped once, when written
	always_comb begin
		cfg_x = CMP_W'(cfg_data);
		if (cfg_x < CMP_W'(bdsmp_pkg::MIN_DIM)) begin
			width_new  = WW'(bdsmp_pkg::MIN_DIM);
		end else if (cfg_x > CMP_W'(MAX_WIDTH)) begin
			width_new  = WW'(MAX_WIDTH);
		end else begin
			width_new  = cfg_x[WW-1:0];
		end
		if (cfg_x < CMP_W'(bdsmp_pkg::MIN_DIM)) begin
			height_new = HW'(bdsmp_pkg::MIN_DIM);
		end else if (cfg_x > CMP_W'(MAX_HEIGHT)) begin
			height_new = HW'(MAX_HEIGHT);
		end else begin
			height_new = cfg_x[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WW'(W_RST);
			height_q    <= HW'(H_RST);
			has_alpha_q <= 1'b1;
		end else if (cfg_write_en) begin
			case (cfg_index)
				bdsmp_pkg::REG_IMAGE_WIDTH:  width_q     <= width_new;
				bdsmp_pkg::REG_IMAGE_HEIGHT: height_q    <= height_new;
				bdsmp_pkg::REG_HAS_ALPHA:    has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_x   = CMP_W'(col_q);
		row_x   = CMP_W'(row_q);
		w_x     = CMP_W'(width_q);
		h_x     = CMP_W'(height_q);
		w_used  = w_x & ~CMP_W'(1);
		h_used  = h_x & ~CMP_W'(1);
		in_img  = (col_x < w_used) && (row_x < h_used);
		row_end = (col_x + CMP_W'(1)) >= w_x;
		img_end = (row_x + CMP_W'(1)) >= h_x;

		info.hold  = in_img && !col_q[0];
		info.store = in_img && col_q[0] && !row_q[0];
		info.emit  = in_img && col_q[0] && row_q[0];
		info.last  = info.emit && (col_x == w_used - CMP_W'(1))
			&& (row_x == h_used - CMP_W'(1));
	end

	assign slot      = col_q[SLOT_W:1];
	assign has_alpha = has_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + WW'(1);
			end
		end
	end

endmodule

@@ sv/box_downsample_2x2.sv @@
// top level of the 2x2 box downsampler
// depends on bdsmp_pkg, bdsmp_pos and bdsmp_ram

// Takes one RGB or RGBA pixel per clock in raster order unless stalled and emits
// one pixel per 2x2 block, the truncated average of its four values per channel.
// The block sustains one input transfer every clock while in_stall is low; a
// result passes from the registered line memory read through the combinational
// add stage into the output queue. A three-entry output queue absorbs output
// stalls; input stall rises once the queue and the add stage together hold three
// results. Configure size and format only while the block is idle.

module box_downsample_2x2 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [bdsmp_pkg::IDX_W-1:0] cfg_index,
	input  logic [bdsmp_pkg::CFG_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  red_in,
	input  logic [7:0]                  green_in,
	input  logic [7:0]                  blue_in,
	input  logic [7:0]                  alpha_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  red_out,
	output logic [7:0]                  green_out,
	output logic [7:0]                  blue_out,
	output logic [7:0]                  alpha_out,
	output logic                        last_of_image
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int PIX_W      = bdsmp_pkg::PIX_W;
	localparam int PAIR_W     = bdsmp_pkg::PAIR_W;
	localparam int QUAD_W     = bdsmp_pkg::QUAD_W;
	localparam int NUM_CH     = bdsmp_pkg::NUM_CH;
	localparam int LINE_W     = NUM_CH * PAIR_W;
	localparam int Q_DEPTH    = 3;

	bdsmp_pkg::pos_info_t     info;
	logic [SLOT_W-1:0]        slot;
	logic                     has_alpha;
	logic                     fire;
	logic [PIX_W-1:0]         px [NUM_CH];
	logic [PIX_W-1:0]         held_q [NUM_CH];
	logic [LINE_W-1:0]        pair;
	logic [LINE_W-1:0]        line_rd;
	logic                     valid_s1;
	logic [LINE_W-1:0]        pair_s1;
	logic                     last_s1;
	logic [QUAD_W-1:0]        quad [NUM_CH];
	bdsmp_pkg::result_t       res;
	bdsmp_pkg::result_t       queue_q [Q_DEPTH];
	logic [1:0]               head_q;
	logic [1:0]               tail_q;
	logic [1:0]               count_q;
	logic                     pop;

	bdsmp_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.SLOT_W     (SLOT_W)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fire         (fire),
		.info         (info),
		.slot         (slot),
		.has_alpha    (has_alpha)
	);

	assign fire = in_valid && !in_stall;

	always_comb begin
		px[0] = red_in;
		px[1] = green_in;
		px[2] = blue_in;
		px[3] = has_alpha ? alpha_in : '0;
		for (int c = 0; c < NUM_CH; c++) begin
			pair[c*PAIR_W +: PAIR_W] = PAIR_W'(held_q[c]) + PAIR_W'(px[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && info.hold) begin
			for (int c = 0; c < NUM_CH; c++) begin
				held_q[c] <= px[c];
			end
		end
	end

	// even rows write pair sums; odd rows read them back a full row later
	bdsmp_ram #(
		.WIDTH (LINE_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (fire && info.store),
		.waddr (slot),
		.wdata (pair),
		.re    (fire && info.emit),
		.raddr (slot),
		.rdata (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire && info.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && info.emit) begin
			pair_s1 <= pair;
			last_s1 <= info.last;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			quad[c] = QUAD_W'(line_rd[c*PAIR_W +: PAIR_W])
				+ QUAD_W'(pair_s1[c*PAIR_W +: PAIR_W]);
		end
		res.red   = quad[0][QUAD_W-1:2];
		res.green = quad[1][QUAD_W-1:2];
		res.blue  = quad[2][QUAD_W-1:2];
		res.alpha = quad[3][QUAD_W-1:2];
		res.last  = last_s1;
	end

	// output queue
	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != 2'd0);
	assign in_stall  = (3'(count_q) + 3'(valid_s1)) >= 3'(Q_DEPTH);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			queue_q[tail_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (valid_s1) begin
				tail_q <= (tail_q == 2'(Q_DEPTH - 1)) ? '0 : tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= (head_q == 2'(Q_DEPTH - 1)) ? '0 : head_q + 2'd1;
			end
			case ({valid_s1, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign red_out       = queue_q[head_q].red;
	assign green_out     = queue_q[head_q].green;
	assign blue_out      = queue_q[head_q].blue;
	assign alpha_out     = queue_q[head_q].alpha;
	assign last_of_image = queue_q[head_q].last;

endmodule
